// ----- rtl/dcs_pkg.sv -----
// shared constants and state type for the divisor count and sum block
package dcs_pkg;

  localparam int INPUT_BITS   = 31;
  localparam int COUNT_BITS   = 12;
  localparam int SUM_BITS     = 34;
  localparam int TRIAL_BITS   = INPUT_BITS / 2 + 1;
  localparam int SQ_BITS      = 2 * TRIAL_BITS + 1;
  localparam int SERIES_BITS  = INPUT_BITS + 1;
  localparam int EXP_BITS     = $clog2(INPUT_BITS) + 1;
  localparam int DIV_CNT_BITS = (INPUT_BITS > 2) ? $clog2(INPUT_BITS) : 1;
  localparam int MUL_CNT_BITS = $clog2(SERIES_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_POWER,
    S_SERIES,
    S_COUNT,
    S_MUL,
    S_FINAL,
    S_DONE
  } state_t;

endpackage

// ----- rtl/dcs_div.sv -----
// restoring divider, one quotient bit per cycle
module dcs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dcs_pkg::INPUT_BITS-1:0] dividend,
  input  logic [dcs_pkg::TRIAL_BITS-1:0] divisor,
  output logic                           done,
  output logic [dcs_pkg::INPUT_BITS-1:0] quotient,
  output logic [dcs_pkg::TRIAL_BITS-1:0] remainder
);
  import dcs_pkg::*;

  localparam logic [DIV_CNT_BITS-1:0] LAST = DIV_CNT_BITS'(INPUT_BITS - 1);

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [TRIAL_BITS-1:0]   dsr;
  logic [TRIAL_BITS:0]     shifted;
  logic [TRIAL_BITS:0]     diff;
  logic                    fits;

  always_comb begin
    shifted = {remainder, quotient[INPUT_BITS-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient <= {quotient[INPUT_BITS-2:0], fits};
      if (fits) begin
        remainder <= diff[TRIAL_BITS-1:0];
      end else begin
        remainder <= shifted[TRIAL_BITS-1:0];
      end
    end
  end

endmodule

// ----- rtl/divisor_count_and_sum.sv -----
// top level: divisor count and divisor sum by trial division
//
// input channel: number with in_valid, block drives in_stall. a request is
// taken when in_valid is high and in_stall is low; in_stall is low only while
// the sequencer is idle, so one number is worked on at a time.
// output channel: divisor_count and divisor_sum with out_valid, receiver
// drives out_stall. one result per request, held in an output register, so a
// new request is taken while the previous result still waits.
// trial divisors d = 2, 3, ... are tried while d*d stays within the
// unfactored rest. each trial runs the shared restoring divider; every
// prime factor found adds a further divide per exponent plus the serial
// sum multiply. a 31-bit prime takes about 46340 trials; zero and one go
// from the check state through the final state to done without a divide.
// reset clears the sequencer and the output valid; no result is pending.
// while out_stall is high the result holds and a finished next result waits
// in the sequencer until the output register frees.
module divisor_count_and_sum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dcs_pkg::INPUT_BITS-1:0] number,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic [dcs_pkg::COUNT_BITS-1:0] divisor_count,
  output logic [dcs_pkg::SUM_BITS-1:0]   divisor_sum,
  output logic                           out_valid,
  input  logic                           out_stall
);
  import dcs_pkg::*;

  localparam logic [MUL_CNT_BITS-1:0] MUL_LAST = MUL_CNT_BITS'(SERIES_BITS - 1);

  state_t state, state_next;

  logic [INPUT_BITS-1:0]   rest;
  logic [TRIAL_BITS-1:0]   d;
  logic [SQ_BITS-1:0]      sq;
  logic [EXP_BITS-1:0]     exps;
  logic [INPUT_BITS-1:0]   power;
  logic [SERIES_BITS-1:0]  series;
  logic [COUNT_BITS-1:0]   count;
  logic [SUM_BITS-1:0]     sum;
  logic [SUM_BITS-1:0]     ma;
  logic [SUM_BITS-1:0]     acc;
  logic [SUM_BITS-1:0]     acc_next;
  logic [SERIES_BITS-1:0]  mb;
  logic [MUL_CNT_BITS-1:0] mcnt;
  logic                    tail;

  logic                    div_start;
  logic                    div_done;
  logic [INPUT_BITS-1:0]   div_quo;
  logic [TRIAL_BITS-1:0]   div_rem;

  logic                    in_take;
  logic                    out_free;
  logic                    rest_big;
  logic                    trial_on;
  logic                    d_step;
  logic                    mul_end;
  logic [INPUT_BITS+TRIAL_BITS-1:0] power_prod;
  logic [COUNT_BITS+EXP_BITS-1:0]   count_prod;

  dcs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rest),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    rest_big   = rest > INPUT_BITS'(1);
    trial_on   = rest_big && (sq <= SQ_BITS'(rest));
    out_free   = !out_valid || !out_stall;
    in_take    = in_valid && !in_stall;
    mul_end    = mcnt == MUL_LAST;
    acc_next   = mb[0] ? acc + ma : acc;
    power_prod = (INPUT_BITS+TRIAL_BITS)'(power) * (INPUT_BITS+TRIAL_BITS)'(d);
    count_prod = (COUNT_BITS+EXP_BITS)'(count) * (COUNT_BITS+EXP_BITS)'(exps + 1'b1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CHECK;
      S_CHECK:  state_next = trial_on ? S_DIV : S_FINAL;
      S_DIV: begin
        if (div_done) begin
          priority if (div_rem == '0) state_next = S_POWER;
          else if (exps != '0)        state_next = S_COUNT;
          else                        state_next = S_CHECK;
        end
      end
      S_POWER:  state_next = S_SERIES;
      S_SERIES: state_next = S_DIV;
      S_COUNT:  state_next = S_MUL;
      S_MUL:    if (mul_end) state_next = tail ? S_DONE : S_CHECK;
      S_FINAL:  state_next = rest_big ? S_MUL : S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    d_step    = 1'b0;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_CHECK:  div_start = trial_on;
      S_SERIES: div_start = 1'b1;
      S_DIV:    d_step = div_done && div_rem != '0 && exps == '0;
      S_MUL:    d_step = mul_end && !tail;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      divisor_count <= count;
      divisor_sum   <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (d_step) begin
      d      <= d + 1'b1;
      sq     <= sq + SQ_BITS'({d, 1'b1});
      exps   <= '0;
      power  <= INPUT_BITS'(1);
      series <= SERIES_BITS'(1);
    end
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          rest   <= number;
          d      <= TRIAL_BITS'(2);
          sq     <= SQ_BITS'(4);
          exps   <= '0;
          power  <= INPUT_BITS'(1);
          series <= SERIES_BITS'(1);
          count  <= COUNT_BITS'(1);
          sum    <= SUM_BITS'(1);
        end
      end
      S_POWER: begin
        rest  <= div_quo;
        exps  <= exps + 1'b1;
        power <= power_prod[INPUT_BITS-1:0];
      end
      S_SERIES: series <= series + SERIES_BITS'(power);
      S_COUNT: begin
        count <= count_prod[COUNT_BITS-1:0];
        ma    <= sum;
        mb    <= series;
        acc   <= '0;
        mcnt  <= '0;
        tail  <= 1'b0;
      end
      S_FINAL: begin
        if (rest_big) begin
          count <= {count[COUNT_BITS-2:0], 1'b0};
          ma    <= sum;
          mb    <= SERIES_BITS'(rest) + 1'b1;
          acc   <= '0;
          mcnt  <= '0;
          tail  <= 1'b1;
        end
      end
      S_MUL: begin
        acc  <= acc_next;
        ma   <= {ma[SUM_BITS-2:0], 1'b0};
        mb   <= {1'b0, mb[SERIES_BITS-1:1]};
        mcnt <= mcnt + 1'b1;
        if (mul_end) begin
          sum <= acc_next;
        end
      end
      default: begin
      end
    endcase
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_rem < d)
    else $error("divider remainder not below the trial divisor");

  a_square_tracks: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> sq == SQ_BITS'(d) * SQ_BITS'(d))
    else $error("running square out of step with trial divisor");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> divisor_count != '0)
    else $error("zero divisor count delivered");

endmodule
